>>> rtl/core/skf_pkg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared widths, register codes, microcode format, the control program and
// the fixed-point helper functions used by the datapath.
// ----------------------------------------------------------------------------
package skf_pkg;

	// Word formats: Q16.16 words and Q4.12 model gains.
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned GAIN_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// Multiplier operands are signed and one bit wider than a word, so that an
	// unsigned word fits as well; the product register holds the full result.
	localparam int unsigned OPND_W = WORD_W + 1;
	localparam int unsigned PROD_W = 2 * OPND_W;

	// Gain division: a signed numerator P1*H*16 and an unsigned denominator
	// round(H*H*P1) + R, which is never saturated.
	localparam int unsigned NUM_SHIFT = 4;
	localparam int unsigned NUM_W     = 53;
	localparam int unsigned DEN_W     = 39;

	// Fixed-point constants.
	localparam int unsigned ONE_Q16   = 65536;
	localparam int unsigned NOISE_DEF = 1000;

	localparam logic [WORD_W-1:0] WORD_SMAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_SMIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] WORD_UMAX = {WORD_W{1'b1}};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATE_GAIN    = 3'd0,
		REG_CONTROL_GAIN  = 3'd1,
		REG_OBSERVE_GAIN  = 3'd2,
		REG_CONTROL_INPUT = 3'd3,
		REG_PROCESS_NOISE = 3'd4,
		REG_MEASURE_NOISE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] state_gain;
		logic signed [GAIN_W-1:0] control_gain;
		logic signed [GAIN_W-1:0] observe_gain;
		logic signed [WORD_W-1:0] control_input;
		logic        [WORD_W-1:0] process_noise;
		logic        [WORD_W-1:0] measure_noise;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		state_gain:    16'sd4096,
		control_gain:  16'sd0,
		observe_gain:  16'sd4096,
		control_input: 32'sd0,
		process_noise: WORD_W'(NOISE_DEF) << 16,
		measure_noise: WORD_W'(NOISE_DEF) << 16
	};

	// Multiplier operand selects.
	typedef enum logic [2:0] {
		A_F, A_B, A_H, A_K, A_FAC, A_T
	} mul_a_t;

	typedef enum logic [2:0] {
		B_X, B_U, B_F, B_P, B_H, B_P1, B_X1, B_Y
	} mul_b_t;

	// Write-back operations; those that use a product take the previous step's.
	typedef enum logic [3:0] {
		WB_NONE, WB_LOAD, WB_ACC, WB_X1, WB_T, WB_Y, WB_P1, WB_S,
		WB_DIV, WB_K, WB_X, WB_FAC, WB_P, WB_EMIT
	} wb_t;

	// Conditions that hold the program at its current step.
	typedef enum logic [1:0] {
		H_NONE, H_NO_INPUT, H_DIV_BUSY, H_OUT_FULL
	} hold_t;

	// Program steps.
	typedef enum logic [4:0] {
		ST_IDLE, ST_FX, ST_BU, ST_FF, ST_HX1, ST_FFP, ST_HH, ST_HH_SAVE,
		ST_HHP1, ST_HP1, ST_DIV_GO, ST_DIV_WAIT, ST_K, ST_KY, ST_KH,
		ST_FAC, ST_FACP1, ST_P, ST_EMIT
	} step_t;

	typedef struct packed {
		logic   mul_en;
		mul_a_t a_sel;
		mul_b_t b_sel;
		wb_t    wb;
		hold_t  hold;
		logic   jump;
		step_t  target;
	} uword_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic   fire;
		uword_t uw;
	} ctrl_t;

	// Status back to the sequencer.
	typedef struct packed {
		logic out_full;
		logic div_busy;
	} stat_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic        [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic [WORD_W-1:0] quot;
	} div_rsp_t;

	// Control program. A step that is not held advances by one or jumps.
	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		w = '0;
		case (pc)
			ST_IDLE: begin
				w.hold = H_NO_INPUT;
				w.wb   = WB_LOAD;
			end
			ST_FX: begin
				w.mul_en = 1'b1; w.a_sel = A_F; w.b_sel = B_X;
			end
			ST_BU: begin
				w.mul_en = 1'b1; w.a_sel = A_B; w.b_sel = B_U;
				w.wb = WB_ACC;
			end
			ST_FF: begin
				w.mul_en = 1'b1; w.a_sel = A_F; w.b_sel = B_F;
				w.wb = WB_X1;
			end
			ST_HX1: begin
				w.mul_en = 1'b1; w.a_sel = A_H; w.b_sel = B_X1;
				w.wb = WB_T;
			end
			ST_FFP: begin
				w.mul_en = 1'b1; w.a_sel = A_T; w.b_sel = B_P;
				w.wb = WB_Y;
			end
			ST_HH: begin
				w.mul_en = 1'b1; w.a_sel = A_H; w.b_sel = B_H;
				w.wb = WB_P1;
			end
			ST_HH_SAVE: begin
				w.wb = WB_T;
			end
			ST_HHP1: begin
				w.mul_en = 1'b1; w.a_sel = A_T; w.b_sel = B_P1;
			end
			ST_HP1: begin
				w.mul_en = 1'b1; w.a_sel = A_H; w.b_sel = B_P1;
				w.wb = WB_S;
			end
			ST_DIV_GO: begin
				w.wb = WB_DIV;
			end
			ST_DIV_WAIT: begin
				w.hold = H_DIV_BUSY;
			end
			ST_K: begin
				w.wb = WB_K;
			end
			ST_KY: begin
				w.mul_en = 1'b1; w.a_sel = A_K; w.b_sel = B_Y;
			end
			ST_KH: begin
				w.mul_en = 1'b1; w.a_sel = A_K; w.b_sel = B_H;
				w.wb = WB_X;
			end
			ST_FAC: begin
				w.wb = WB_FAC;
			end
			ST_FACP1: begin
				w.mul_en = 1'b1; w.a_sel = A_FAC; w.b_sel = B_P1;
			end
			ST_P: begin
				w.wb = WB_P;
			end
			ST_EMIT: begin
				w.hold   = H_OUT_FULL;
				w.wb     = WB_EMIT;
				w.jump   = 1'b1;
				w.target = ST_IDLE;
			end
			default: begin
				w.jump   = 1'b1;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	// Arithmetic shift right that rounds half up.
	function automatic logic signed [PROD_W-1:0] rnd_shift(
		input logic signed [PROD_W-1:0] v,
		input int unsigned              sh
	);
		logic signed [PROD_W-1:0] half;
		half = PROD_W'(1) << (sh - 1);
		return (v + half) >>> sh;
	endfunction

	// Saturate a wide signed value to a signed word.
	function automatic logic [WORD_W-1:0] sat_s32(input logic signed [PROD_W-1:0] v);
		logic pos_ovf;
		logic neg_ovf;
		logic [WORD_W-1:0] r;
		pos_ovf = !v[PROD_W-1] && (|v[PROD_W-2:WORD_W-1]);
		neg_ovf = v[PROD_W-1] && !(&v[PROD_W-2:WORD_W-1]);
		if (pos_ovf) begin
			r = WORD_SMAX;
		end else if (neg_ovf) begin
			r = WORD_SMIN;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	// Clamp a wide signed value to an unsigned word.
	function automatic logic [WORD_W-1:0] sat_u32(input logic signed [PROD_W-1:0] v);
		logic [WORD_W-1:0] r;
		if (v[PROD_W-1]) begin
			r = '0;
		end else if (|v[PROD_W-2:WORD_W]) begin
			r = WORD_UMAX;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// Fixed-point one-dimensional Kalman filter: predict, gain, update, one
// result word per measurement, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A measurement is carried from acceptance through the control program and
// the 32-step restoring divider that forms the gain; when the gain
// denominator is zero or the quotient needs more than a word the divider
// finishes at once. The first measurement after reset seeds the estimate.
// The user must write registers through the configuration port only while
// no measurement is in progress; the block itself does not enforce this.
// A finished result waits in the output register while the next is taken.
module scalar_kalman_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic        [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [skf_pkg::WORD_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [skf_pkg::WORD_W-1:0]   measurement,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [skf_pkg::WORD_W-1:0]   estimate,
	output logic        [skf_pkg::WORD_W-1:0]   variance,
	output logic signed [skf_pkg::WORD_W-1:0]   kalman_gain
);
	import skf_pkg::*;

	cfg_t     cfg_q;
	ctrl_t    ctrl;
	stat_t    stat;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     out_full;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_STATE_GAIN:    cfg_q.state_gain    <= cfg_data[GAIN_W-1:0];
				REG_CONTROL_GAIN:  cfg_q.control_gain  <= cfg_data[GAIN_W-1:0];
				REG_OBSERVE_GAIN:  cfg_q.observe_gain  <= cfg_data[GAIN_W-1:0];
				REG_CONTROL_INPUT: cfg_q.control_input <= cfg_data;
				REG_PROCESS_NOISE: cfg_q.process_noise <= cfg_data;
				REG_MEASURE_NOISE: cfg_q.measure_noise <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stat.out_full = out_full;
	assign stat.div_busy = div_rsp.busy;

	skf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_ready (in_ready)
	);

	skf_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.ctrl        (ctrl),
		.measurement (measurement),
		.div_rsp     (div_rsp),
		.div_req     (div_req),
		.out_full    (out_full),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.estimate    (estimate),
		.variance    (variance),
		.kalman_gain (kalman_gain)
	);

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

>>> rtl/core/skf_div.sv
// ----------------------------------------------------------------------------
// Gain divider
// Restoring divider, one quotient bit per cycle, that forms the signed,
// saturated gain from the numerator and denominator of the update step.
// ----------------------------------------------------------------------------
module skf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  skf_pkg::div_req_t  req,
	output skf_pkg::div_rsp_t  rsp
);
	import skf_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);
	localparam int unsigned HI_W  = NUM_W - WORD_W;

	typedef enum logic {
		D_IDLE,
		D_RUN
	} dstate_t;

	dstate_t           state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [WORD_W-1:0] quo_q;
	logic              neg_q;
	logic [WORD_W-1:0] res_q;

	logic [NUM_W-1:0]  mag;
	logic [HI_W-1:0]   hi;
	logic [DEN_W:0]    rem2;
	logic [DEN_W+1:0]  trial;
	logic              borrow;
	logic [DEN_W-1:0]  rem_nx;
	logic [WORD_W-1:0] quo_nx;
	logic [WORD_W-1:0] fin;

	// Magnitude of the numerator and its upper part, which seeds the remainder.
	assign mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
	assign hi  = mag[NUM_W-1:WORD_W];

	// One trial subtraction per cycle.
	assign rem2   = {rem_q, quo_q[WORD_W-1]};
	assign trial  = {1'b0, rem2} - {2'b00, den_q};
	assign borrow = trial[DEN_W+1];
	assign rem_nx = borrow ? rem2[DEN_W-1:0] : trial[DEN_W-1:0];
	assign quo_nx = {quo_q[WORD_W-2:0], !borrow};

	// Apply the sign and saturate to a signed word.
	always_comb begin
		if (neg_q) begin
			fin = (quo_nx > WORD_SMIN) ? WORD_SMIN : (WORD_W'(0) - quo_nx);
		end else begin
			fin = quo_nx[WORD_W-1] ? WORD_SMAX : quo_nx;
		end
	end

	// Divider control and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			quo_q   <= '0;
			neg_q   <= 1'b0;
			res_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						neg_q <= req.num[NUM_W-1];
						den_q <= req.den;
						if (req.den == '0) begin
							res_q <= '0;
						end else if (DEN_W'(hi) >= req.den) begin
							// The quotient needs more than a word: saturate now.
							res_q <= req.num[NUM_W-1] ? WORD_SMIN : WORD_SMAX;
						end else begin
							rem_q   <= DEN_W'(hi);
							quo_q   <= mag[WORD_W-1:0];
							cnt_q   <= CNT_W'(WORD_W - 1);
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						res_q   <= fin;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign rsp.busy = (state_q == D_RUN);
	assign rsp.quot = res_q;

endmodule

>>> rtl/core/skf_seq.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control program; a step may hold on a condition
// and may jump when it completes.
// ----------------------------------------------------------------------------
module skf_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  skf_pkg::stat_t  stat,
	output skf_pkg::ctrl_t  ctrl,
	output logic            in_ready
);
	import skf_pkg::*;

	step_t  pc_q;
	uword_t uw;
	logic   hold;

	// Control word of the current step.
	assign uw = ucode(pc_q);

	// Hold condition of the current step.
	always_comb begin
		case (uw.hold)
			H_NONE:     hold = 1'b0;
			H_NO_INPUT: hold = !in_valid;
			H_DIV_BUSY: hold = stat.div_busy;
			H_OUT_FULL: hold = stat.out_full;
			default:    hold = 1'b0;
		endcase
	end

	// The idle step is the only one that takes a word.
	assign in_ready  = (uw.hold == H_NO_INPUT);
	assign ctrl.fire = !hold;
	assign ctrl.uw   = uw;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (!hold) begin
			pc_q <= uw.jump ? uw.target : step_t'(pc_q + 1'b1);
		end
	end

endmodule

>>> rtl/core/skf_dpath.sv
// ----------------------------------------------------------------------------
// Filter datapath
// Shared multiplier with a product register, the working registers of one
// filter step, the post-product rounding and saturation, and the result word.
// ----------------------------------------------------------------------------
module skf_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  skf_pkg::cfg_t                       cfg,
	input  skf_pkg::ctrl_t                      ctrl,
	input  logic signed [skf_pkg::WORD_W-1:0]   measurement,
	input  skf_pkg::div_rsp_t                   div_rsp,
	output skf_pkg::div_req_t                   div_req,
	output logic                                out_full,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [skf_pkg::WORD_W-1:0]   estimate,
	output logic        [skf_pkg::WORD_W-1:0]   variance,
	output logic signed [skf_pkg::WORD_W-1:0]   kalman_gain
);
	import skf_pkg::*;

	// F*x and B*u each fit 48 signed bits.
	localparam int unsigned ACC_W = 49;
	// F*F and H*H are at most 2^30.
	localparam int unsigned T_W = 31;

	// Filter state.
	logic signed [WORD_W-1:0] x_q;
	logic        [WORD_W-1:0] p_q;
	logic                     seen_q;

	// Working registers of one step.
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic        [T_W-1:0]    t_q;
	logic signed [WORD_W-1:0] z_q;
	logic signed [WORD_W-1:0] x1_q;
	logic        [WORD_W-1:0] p1_q;
	logic        [DEN_W-1:0]  s_q;
	logic signed [WORD_W-1:0] y_q;
	logic signed [WORD_W-1:0] k_q;
	logic signed [WORD_W-1:0] fac_q;

	// Result word.
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] est_q;
	logic        [WORD_W-1:0] var_q;
	logic signed [WORD_W-1:0] gain_q;

	logic signed [OPND_W-1:0] opa;
	logic signed [OPND_W-1:0] opb;
	logic signed [WORD_W-1:0] hx1;
	logic                     wb_fire;

	assign wb_fire = ctrl.fire;

	// Multiplier operand selection.
	always_comb begin
		case (ctrl.uw.a_sel)
			A_F:     opa = OPND_W'($signed(cfg.state_gain));
			A_B:     opa = OPND_W'($signed(cfg.control_gain));
			A_H:     opa = OPND_W'($signed(cfg.observe_gain));
			A_K:     opa = OPND_W'(k_q);
			A_FAC:   opa = OPND_W'(fac_q);
			A_T:     opa = $signed(OPND_W'(t_q));
			default: opa = '0;
		endcase
	end

	always_comb begin
		case (ctrl.uw.b_sel)
			B_X:     opb = OPND_W'(x_q);
			B_U:     opb = OPND_W'($signed(cfg.control_input));
			B_F:     opb = OPND_W'($signed(cfg.state_gain));
			B_P:     opb = $signed(OPND_W'(p_q));
			B_H:     opb = OPND_W'($signed(cfg.observe_gain));
			B_P1:    opb = $signed(OPND_W'(p1_q));
			B_X1:    opb = OPND_W'(x1_q);
			B_Y:     opb = OPND_W'(y_q);
			default: opb = '0;
		endcase
	end

	// Predicted measurement, saturated before the innovation is formed.
	assign hx1 = $signed(sat_s32(rnd_shift(prod_q, 12)));

	// Gain division request: numerator P1*H*16 and the stored denominator.
	assign div_req.start = wb_fire && (ctrl.uw.wb == WB_DIV);
	assign div_req.num   = {prod_q[NUM_W-NUM_SHIFT-1:0], {NUM_SHIFT{1'b0}}};
	assign div_req.den   = s_q;

	// Product register and the working registers of a step.
	always_ff @(posedge clk) begin
		if (wb_fire && ctrl.uw.mul_en) begin
			prod_q <= opa * opb;
		end
		if (wb_fire) begin
			case (ctrl.uw.wb)
				WB_LOAD: z_q   <= measurement;
				WB_ACC:  acc_q <= prod_q[ACC_W-1:0];
				WB_X1:   x1_q  <= $signed(sat_s32(rnd_shift(PROD_W'(acc_q) + prod_q, 12)));
				WB_T:    t_q   <= prod_q[T_W-1:0];
				WB_Y:    y_q   <= $signed(sat_s32(PROD_W'(z_q) - PROD_W'(hx1)));
				WB_P1:   p1_q  <= sat_u32(rnd_shift(prod_q, 24)
					+ $signed(PROD_W'(cfg.process_noise)));
				WB_S:    s_q   <= DEN_W'(rnd_shift(prod_q, 24)
					+ $signed(PROD_W'(cfg.measure_noise)));
				WB_K:    k_q   <= $signed(div_rsp.quot);
				WB_FAC:  fac_q <= $signed(sat_s32($signed(PROD_W'(ONE_Q16))
					- rnd_shift(prod_q, 12)));
				default: ;
			endcase
		end
	end

	// Filter state and the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			p_q         <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
			est_q       <= '0;
			var_q       <= '0;
			gain_q      <= '0;
		end else begin
			if (wb_fire) begin
				case (ctrl.uw.wb)
					WB_LOAD: begin
						// The first measurement seeds the estimate.
						if (!seen_q) begin
							x_q    <= measurement;
							seen_q <= 1'b1;
						end
					end
					WB_X:    x_q <= $signed(sat_s32(PROD_W'(x1_q) + rnd_shift(prod_q, 16)));
					WB_P:    p_q <= sat_u32(rnd_shift(prod_q, 16));
					default: ;
				endcase
			end
			if (wb_fire && (ctrl.uw.wb == WB_EMIT)) begin
				out_valid_q <= 1'b1;
				est_q       <= x_q;
				var_q       <= p_q;
				gain_q      <= k_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_full    = out_valid_q && !out_ready;
	assign out_valid   = out_valid_q;
	assign estimate    = est_q;
	assign variance    = var_q;
	assign kalman_gain = gain_q;

endmodule

>>> rtl/core/skf_checker.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter port checker
// Assertions on the handshakes of the top level, attached by a bind.
// ----------------------------------------------------------------------------
module skf_port_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [skf_pkg::WORD_W-1:0]   estimate,
	input logic        [skf_pkg::WORD_W-1:0]   variance,
	input logic signed [skf_pkg::WORD_W-1:0]   kalman_gain
);

	// Once a measurement is taken the block is busy with it.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("skf: ready again straight after a measurement was taken");

	// A new result only appears at the end of a filter step, never from idle.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("skf: result word appeared while the block was idle");

	// A result word that is not taken stays put.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(estimate)
			&& $stable(variance) && $stable(kalman_gain))
		else $error("skf: stalled result word changed or was dropped");

endmodule

bind scalar_kalman_filter skf_port_checker u_skf_port_checker (.*);

>>> sim/skf_checker.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter checker
// Watches the configuration port and both word channels of the filter. Keeps
// its own copy of the registers and of the filter state, predicts every
// result word from each accepted measurement and compares the words that
// leave the block, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skf_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic        [skf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [skf_pkg::WORD_W-1:0]   cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [skf_pkg::WORD_W-1:0]   measurement,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [skf_pkg::WORD_W-1:0]   estimate,
	input  logic        [skf_pkg::WORD_W-1:0]   variance,
	input  logic signed [skf_pkg::WORD_W-1:0]   kalman_gain,
	output int unsigned                         pending,
	output int unsigned                         failures
);

	import skf_pkg::*;

	// Wide enough that no product of the update ever wraps.
	typedef logic signed [95:0] wide_t;

	typedef struct packed {
		logic [WORD_W-1:0] estimate;
		logic [WORD_W-1:0] variance;
		logic [WORD_W-1:0] gain;
	} filter_word_t;

	localparam wide_t S32_MAX = 96'sd2147483647;
	localparam wide_t S32_MIN = -96'sd2147483648;
	localparam wide_t U32_MAX = 96'sd4294967295;

	cfg_t              regs;
	logic [WORD_W-1:0] track_est;
	logic [WORD_W-1:0] track_cov;
	logic              seeded;
	filter_word_t      predicted_q[$];
	filter_word_t      got;
	filter_word_t      want;
	int unsigned       shown;

	// Shift right by sh bits, rounding half up.
	function automatic wide_t round_shift(input wide_t v, input int unsigned sh);
		wide_t half;
		half = wide_t'(1) <<< (sh - 1);
		return (v + half) >>> sh;
	endfunction

	function automatic wide_t clamp_s32(input wide_t v);
		if (v > S32_MAX) begin
			return S32_MAX;
		end
		if (v < S32_MIN) begin
			return S32_MIN;
		end
		return v;
	endfunction

	function automatic wide_t clamp_u32(input wide_t v);
		if (v < 0) begin
			return '0;
		end
		if (v > U32_MAX) begin
			return U32_MAX;
		end
		return v;
	endfunction

	// One filter step: predict, form the gain, update. Advances the tracked
	// estimate and covariance and returns the word the block should emit.
	function automatic filter_word_t filter_step(input logic [WORD_W-1:0] z_word);
		wide_t f, b, h, u, z, q, r, x, p;
		wide_t x1, p1, s, num, mag, kg, hx1, y, xn, fac, pn;
		filter_word_t res;
		// The first measurement after reset seeds the estimate.
		if (!seeded) begin
			track_est = z_word;
			seeded    = 1'b1;
		end
		f = wide_t'($signed(regs.state_gain));
		b = wide_t'($signed(regs.control_gain));
		h = wide_t'($signed(regs.observe_gain));
		u = wide_t'($signed(regs.control_input));
		q = wide_t'(regs.process_noise);
		r = wide_t'(regs.measure_noise);
		z = wide_t'($signed(z_word));
		x = wide_t'($signed(track_est));
		p = wide_t'(track_cov);

		// Prediction.
		x1 = clamp_s32(round_shift(f * x + b * u, 12));
		p1 = clamp_u32(round_shift(f * f * p, 24) + q);

		// Gain; the denominator is kept wide and a zero one gives no gain.
		s   = round_shift(h * h * p1, 24) + r;
		num = p1 * h * 16;
		if (s == 0) begin
			kg = '0;
		end else begin
			mag = (num < 0) ? -num : num;
			mag = mag / s;
			kg  = clamp_s32((num < 0) ? -mag : mag);
		end

		// Update; a negative covariance is clamped to zero.
		hx1 = clamp_s32(round_shift(h * x1, 12));
		y   = clamp_s32(z - hx1);
		xn  = clamp_s32(x1 + round_shift(kg * y, 16));
		fac = clamp_s32(65536 - round_shift(kg * h, 12));
		pn  = clamp_u32(round_shift(fac * p1, 16));

		track_est    = xn[WORD_W-1:0];
		track_cov    = pn[WORD_W-1:0];
		res.estimate = xn[WORD_W-1:0];
		res.variance = pn[WORD_W-1:0];
		res.gain     = kg[WORD_W-1:0];
		return res;
	endfunction

	// Result words are checked before a measurement of the same edge is
	// predicted, and registers change only after both.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs      = CFG_RESET;
			track_est = '0;
			track_cov = '0;
			seeded    = 1'b0;
			predicted_q.delete();
			shown     = 0;
			failures  = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {estimate, variance, kalman_gain};
				if (predicted_q.size() == 0) begin
					failures++;
					if (shown < 10) begin
						$display("%0t: result word with none expected: est %h var %h gain %h",
							$realtime, got.estimate, got.variance, got.gain);
					end
					shown++;
				end else begin
					want = predicted_q.pop_front();
					if (got.estimate !== want.estimate || got.variance !== want.variance ||
							got.gain !== want.gain) begin
						failures++;
						if (shown < 10) begin
							$display("%0t: result mismatch: estimate exp %h got %h, variance exp %h got %h, gain exp %h got %h",
								$realtime, want.estimate, got.estimate, want.variance,
								got.variance, want.gain, got.gain);
						end
						shown++;
					end
				end
			end

			if (in_valid && in_ready) begin
				predicted_q.push_back(filter_step(measurement));
			end

			// Register writes; an index past the last register is ignored.
			if (cfg_wen) begin
				case (cfg_index)
					REG_STATE_GAIN:    regs.state_gain    = cfg_data[GAIN_W-1:0];
					REG_CONTROL_GAIN:  regs.control_gain  = cfg_data[GAIN_W-1:0];
					REG_OBSERVE_GAIN:  regs.observe_gain  = cfg_data[GAIN_W-1:0];
					REG_CONTROL_INPUT: regs.control_input = cfg_data;
					REG_PROCESS_NOISE: regs.process_noise = cfg_data;
					REG_MEASURE_NOISE: regs.measure_noise = cfg_data;
					default: ;
				endcase
			end
		end
		pending = predicted_q.size();
	end

endmodule

>>> sim/tb_scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives measurements and register settings into the filter, stalls the
// result channel at random and leaves prediction and comparison to the
// checker. A directed opening covers the extremes and the special cases,
// then random phases with fresh settings run until about 1450 words are in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;

	import skf_pkg::*;

	localparam int TOTAL_WORDS     = 1450;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT  = 4000;

	// Indexes beyond the last register, which the block must ignore.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wen;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [WORD_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [WORD_W-1:0] measurement;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [WORD_W-1:0] estimate;
	logic        [WORD_W-1:0] variance;
	logic signed [WORD_W-1:0] kalman_gain;
	int unsigned              pending;
	int unsigned              failures;

	int                       words_sent;
	int                       rx_hold;
	bit                       rx_calm;
	bit                       tx_eager;
	int                       stall_count;

	scalar_kalman_filter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.estimate    (estimate),
		.variance    (variance),
		.kalman_gain (kalman_gain)
	);

	skf_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.estimate    (estimate),
		.variance    (variance),
		.kalman_gain (kalman_gain),
		.pending     (pending),
		.failures    (failures)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle lengths: mostly short, now and then long. The sender may offer
	// back to back; the receiver always drops ready between its bursts.
	function automatic int pick_gap(input bit for_rx);
		int roll;
		roll = $urandom_range(0, 99);
		if (!for_rx && roll < 55) begin
			return 0;
		end
		if (roll < 88) begin
			return $urandom_range(1, 4);
		end
		if (roll < 98) begin
			return $urandom_range(5, 24);
		end
		return $urandom_range(30, 100);
	endfunction

	// Q4.12 factor: mostly near one, sometimes an extreme or anything at all.
	function automatic logic [GAIN_W-1:0] pick_gain();
		logic [WORD_W-1:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 7))
			0: return raw[GAIN_W-1:0];
			1: begin
				case ($urandom_range(0, 4))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'h0001;
					default: return 16'hFFFF;
				endcase
			end
			default: return GAIN_W'(3496 + $urandom_range(0, 1200));
		endcase
	endfunction

	// Q16.16 word: mostly small, either signed or as a variance, otherwise an
	// extreme or a full random pattern.
	function automatic logic [WORD_W-1:0] pick_word(input bit as_variance);
		logic [WORD_W-1:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 7))
			0: return raw;
			1: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					3: return 32'h7FFF_FFFF;
					default: return 32'h0000_0001;
				endcase
			end
			default: begin
				if (as_variance) begin
					return {8'h00, raw[23:0]};
				end
				return {{12{raw[31]}}, raw[19:0]};
			end
		endcase
	endfunction

	// One register write per cycle; the caller drops the enable afterwards.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	// Offer one measurement word after an optional gap and hold it until taken.
	task automatic offer_word(input logic [WORD_W-1:0] value, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		measurement <= value;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		words_sent++;
	endtask

	// Stop offering and wait until every predicted result word has left.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// Result side: long hold-off on request, calm stretches, or random bursts.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end else if (rx_calm) begin
				out_ready <= 1'b1;
				@(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_ready <= 1'b0;
				repeat (pick_gap(1'b1)) @(negedge clk);
			end
		end
	end

	// Watchdog: too long without any word moving on either channel.
	initial begin
		stall_count = 0;
		@(posedge arst_n);
		while (stall_count < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_count = 0;
			end else begin
				stall_count++;
			end
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int               phase_no;
		int               n;
		logic [WORD_W-1:0] data;
		arst_n      = 1'b0;
		cfg_wen     = 1'b0;
		cfg_index   = REG_STATE_GAIN;
		cfg_data    = '0;
		in_valid    = 1'b0;
		measurement = '0;
		words_sent  = 0;
		rx_hold     = 0;
		rx_calm     = 1'b0;
		tx_eager    = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings; the first word seeds the estimate.
		offer_word(32'h0001_0000, 0);
		offer_word(32'h7FFF_FFFF, pick_gap(1'b0));
		offer_word(32'h8000_0000, pick_gap(1'b0));
		offer_word(32'h0000_0000, pick_gap(1'b0));
		offer_word(32'hFFFF_FFFF, pick_gap(1'b0));
		wait_drained();

		// Extreme factors and noise: every saturation point of the update.
		write_reg(REG_STATE_GAIN,    32'h0000_7FFF);
		write_reg(REG_CONTROL_GAIN,  32'h0000_8000);
		write_reg(REG_OBSERVE_GAIN,  32'h0000_8000);
		write_reg(REG_CONTROL_INPUT, 32'h7FFF_FFFF);
		write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
		write_reg(REG_MEASURE_NOISE, 32'hFFFF_FFFF);
		cfg_wen <= 1'b0;
		offer_word(32'h7FFF_FFFF, 0);
		offer_word(32'h8000_0000, pick_gap(1'b0));
		offer_word(32'h1234_5678, pick_gap(1'b0));
		wait_drained();

		// Zero denominator: no covariance carried over and no noise at all.
		write_reg(REG_STATE_GAIN,    32'h0000_0000);
		write_reg(REG_CONTROL_GAIN,  32'h0000_7FFF);
		write_reg(REG_OBSERVE_GAIN,  32'h0000_1000);
		write_reg(REG_CONTROL_INPUT, 32'h8000_0000);
		write_reg(REG_PROCESS_NOISE, 32'h0000_0000);
		write_reg(REG_MEASURE_NOISE, 32'h0000_0000);
		cfg_wen <= 1'b0;
		offer_word(32'h7FFF_FFFF, 0);
		offer_word(32'h8000_0000, pick_gap(1'b0));
		wait_drained();

		// Negative covariance: a tiny observation factor whose rounded
		// denominator falls short, so the gain overshoots.
		write_reg(REG_CONTROL_GAIN,  32'h0000_0000);
		write_reg(REG_OBSERVE_GAIN,  32'h0000_0001);
		write_reg(REG_PROCESS_NOISE, 32'h0166_0000);
		cfg_wen <= 1'b0;
		offer_word(32'h0002_0000, 0);
		offer_word(32'hFFFE_0000, pick_gap(1'b0));
		wait_drained();
		write_reg(REG_OBSERVE_GAIN, 32'hFFFF_FFFF);
		cfg_wen <= 1'b0;
		offer_word(32'h0003_0000, 0);
		wait_drained();

		// Zero denominator with a live covariance, plus writes to unused
		// indexes that must change nothing.
		write_reg(REG_SPARE_LO,      32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI,      32'hFFFF_FFFF);
		write_reg(REG_STATE_GAIN,    32'h0000_1000);
		write_reg(REG_OBSERVE_GAIN,  32'h0000_0000);
		write_reg(REG_PROCESS_NOISE, 32'h0010_0000);
		cfg_wen <= 1'b0;
		offer_word(32'h4000_0000, 0);
		offer_word(32'hC000_0000, pick_gap(1'b0));
		wait_drained();

		// Most negative transition factor with the opposite control extremes.
		write_reg(REG_STATE_GAIN,    32'hFFFF_8000);
		write_reg(REG_CONTROL_GAIN,  32'h0000_7FFF);
		write_reg(REG_OBSERVE_GAIN,  32'h0000_7FFF);
		write_reg(REG_CONTROL_INPUT, 32'h8000_0000);
		write_reg(REG_PROCESS_NOISE, 32'h0001_0000);
		write_reg(REG_MEASURE_NOISE, 32'h0000_0001);
		cfg_wen <= 1'b0;
		offer_word(32'h8000_0000, 0);
		offer_word(32'h7FFF_FFFF, pick_gap(1'b0));
		offer_word(32'h0000_0001, pick_gap(1'b0));
		wait_drained();

		// Random phases; each may write fresh settings while idle, the first all.
		phase_no = 0;
		while (words_sent < TOTAL_WORDS) begin
			if (phase_no == 0 || $urandom_range(0, 1)) begin
				data = $urandom;
				data[GAIN_W-1:0] = pick_gain();
				write_reg(REG_STATE_GAIN, data);
			end
			if (phase_no == 0 || $urandom_range(0, 1)) begin
				data = $urandom;
				data[GAIN_W-1:0] = pick_gain();
				write_reg(REG_CONTROL_GAIN, data);
			end
			if (phase_no == 0 || $urandom_range(0, 1)) begin
				data = $urandom;
				data[GAIN_W-1:0] = pick_gain();
				write_reg(REG_OBSERVE_GAIN, data);
			end
			if (phase_no == 0 || $urandom_range(0, 1)) begin
				write_reg(REG_CONTROL_INPUT, pick_word(1'b0));
			end
			if (phase_no == 0 || $urandom_range(0, 1)) begin
				write_reg(REG_PROCESS_NOISE, pick_word(1'b1));
			end
			if (phase_no == 0 || $urandom_range(0, 1)) begin
				write_reg(REG_MEASURE_NOISE, pick_word(1'b1));
			end
			if ($urandom_range(0, 9) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
			end
			cfg_wen <= 1'b0;

			// The second phase holds the result side off while the sender
			// keeps offering, so the block fills up and refuses input.
			if (phase_no == 1) begin
				n        = 30;
				tx_eager = 1'b1;
				rx_calm  = 1'b0;
				rx_hold  = HOLD_OFF_CYCLES;
			end else begin
				n        = $urandom_range(20, 120);
				tx_eager = ($urandom_range(0, 3) == 0);
				rx_calm  = ($urandom_range(0, 3) == 0);
			end

			for (int i = 0; i < n && words_sent < TOTAL_WORDS; i++) begin
				offer_word(pick_word(1'b0), tx_eager ? 0 : pick_gap(1'b0));
			end
			wait_drained();
			phase_no++;
		end

		rx_calm = 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/skf_pkg.sv
rtl/core/skf_div.sv
rtl/core/skf_seq.sv
rtl/core/skf_dpath.sv
rtl/core/scalar_kalman_filter.sv
rtl/core/skf_checker.sv
sim/skf_checker.sv
sim/tb_scalar_kalman_filter.sv
